[hw/rtl/bls_pkg.sv]
// bls_pkg: shared types and codes for the bounded list store
// holds action and status codes, default sizes, and the controller/datapath structs
// no dependencies
package bls_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int ACTION_W   = 3;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = 32;
  localparam int POSITION_W = 8;
  localparam int FOUND_W    = 4;
  localparam int COUNT_W    = 5;

  // actions
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ       = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SEARCH     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd5;

  // result status
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // read offset source
  localparam logic [1:0] RD_FRONT = 2'd0;
  localparam logic [1:0] RD_BACK  = 2'd1;
  localparam logic [1:0] RD_POS   = 2'd2;
  localparam logic [1:0] RD_NEXT  = 2'd3;

  // result data source
  localparam logic [1:0] RES_PLAIN = 2'd0;
  localparam logic [1:0] RES_MEM   = 2'd1;
  localparam logic [1:0] RES_FOUND = 2'd2;

  typedef struct packed {
    logic                load;
    logic                push;
    logic                pop_front;
    logic                pop_back;
    logic                clear;
    logic                rd;
    logic [1:0]          rd_src;
    logic                res;
    logic [1:0]          res_kind;
    logic [STATUS_W-1:0] res_status;
  } bls_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                full;
    logic                empty;
    logic                pos_ok;
    logic                match;
    logic                more;
  } bls_stat_t;

endpackage

[hw/rtl/bls_ctrl.sv]
// bls_ctrl: sequencer for the bounded list store
// decodes the latched action and steps the datapath; uses bls_pkg
module bls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bls_pkg::bls_stat_t st,
  output bls_pkg::bls_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_src     = bls_pkg::RD_FRONT;
    cmd.res_kind   = bls_pkg::RES_PLAIN;
    cmd.res_status = bls_pkg::ST_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        unique case (st.action) inside
          bls_pkg::ACT_PUSH_FRONT: begin
            cmd.res = 1'b1;
            if (st.full) begin
              cmd.res_status = bls_pkg::ST_FULL;
            end else begin
              cmd.push       = 1'b1;
              cmd.res_status = bls_pkg::ST_DONE;
            end
          end
          bls_pkg::ACT_POP_FRONT, bls_pkg::ACT_POP_BACK: begin
            if (st.empty) begin
              cmd.res = 1'b1;
            end else begin
              cmd.rd     = 1'b1;
              cmd.rd_src = (st.action == bls_pkg::ACT_POP_FRONT) ?
                           bls_pkg::RD_FRONT : bls_pkg::RD_BACK;
              state_next = S_WAIT;
            end
          end
          bls_pkg::ACT_READ: begin
            if (!st.pos_ok) begin
              cmd.res = 1'b1;
            end else begin
              cmd.rd     = 1'b1;
              cmd.rd_src = bls_pkg::RD_POS;
              state_next = S_WAIT;
            end
          end
          bls_pkg::ACT_SEARCH: begin
            if (st.empty) begin
              cmd.res = 1'b1;
            end else begin
              cmd.rd     = 1'b1;
              cmd.rd_src = bls_pkg::RD_FRONT;
              state_next = S_SCAN;
            end
          end
          bls_pkg::ACT_CLEAR: begin
            cmd.clear      = 1'b1;
            cmd.res        = 1'b1;
            cmd.res_status = bls_pkg::ST_DONE;
          end
          default: begin
            cmd.res = 1'b1;
          end
        endcase
      end
      S_WAIT: begin
        // memory word is ready; pops retire the entry now
        cmd.res        = 1'b1;
        cmd.res_kind   = bls_pkg::RES_MEM;
        cmd.res_status = bls_pkg::ST_DONE;
        cmd.pop_front  = (st.action == bls_pkg::ACT_POP_FRONT);
        cmd.pop_back   = (st.action == bls_pkg::ACT_POP_BACK);
        state_next     = S_IDLE;
      end
      S_SCAN: begin
        if (st.match) begin
          cmd.res        = 1'b1;
          cmd.res_kind   = bls_pkg::RES_FOUND;
          cmd.res_status = bls_pkg::ST_DONE;
          state_next     = S_IDLE;
        end else if (st.more) begin
          cmd.rd     = 1'b1;
          cmd.rd_src = bls_pkg::RD_NEXT;
        end else begin
          cmd.res    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/bls_dp.sv]
// bls_dp: storage and result path for the bounded list store
// holds the entry memory, head slot, fill count, request and result registers; uses bls_pkg
module bls_dp #(
  parameter int DEPTH     = bls_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bls_pkg::WORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bls_pkg::bls_cmd_t                      cmd,
  output bls_pkg::bls_stat_t                     st,
  input  logic [bls_pkg::ACTION_W-1:0]           action,
  input  logic signed [bls_pkg::VALUE_W-1:0]     value,
  input  logic [bls_pkg::POSITION_W-1:0]         position,
  output logic                                   done,
  output logic [bls_pkg::STATUS_W-1:0]           status,
  output logic signed [bls_pkg::VALUE_W-1:0]     data,
  output logic [bls_pkg::FOUND_W-1:0]            found_at,
  output logic [bls_pkg::COUNT_W-1:0]            count,
  output logic                                   is_empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > bls_pkg::POSITION_W) ? FW + 1 : bls_pkg::POSITION_W + 1;
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [FW-1:0] FULL_N  = FW'(DEPTH);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] mem_q;

  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  logic [FW-1:0] fill_next;
  logic [AW-1:0] idx;

  logic [bls_pkg::ACTION_W-1:0]   req_action;
  logic [WORD_BITS-1:0]           req_word;
  logic [bls_pkg::POSITION_W-1:0] req_pos;

  logic [AW-1:0] rd_off;
  logic [AW:0]   slot_sum;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] push_slot;
  logic [63:0]   q_wide;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_word   <= WORD_BITS'({32'b0, value});
      req_pos    <= position;
    end
  end

  // ring offset to slot, one compare and subtract
  always_comb begin
    unique case (cmd.rd_src)
      bls_pkg::RD_FRONT: rd_off = '0;
      bls_pkg::RD_BACK:  rd_off = AW'(fill - FW'(1));
      bls_pkg::RD_POS:   rd_off = AW'(req_pos);
      bls_pkg::RD_NEXT:  rd_off = idx + AW'(1);
      default:           rd_off = '0;
    endcase
    slot_sum = (AW + 1)'(head) + (AW + 1)'(rd_off);
    if (slot_sum >= DEPTH_S) begin
      slot_sum = slot_sum - DEPTH_S;
    end
    rd_slot   = slot_sum[AW-1:0];
    push_slot = (head == '0) ? LAST : head - AW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[push_slot] <= req_word;
    end
    if (cmd.rd) begin
      mem_q <= mem[rd_slot];
    end
  end

  // scan position, tracks the entry whose word sits in mem_q
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      idx <= rd_off;
    end
  end

  always_comb begin
    fill_next = fill;
    if (cmd.push) begin
      fill_next = fill + FW'(1);
    end else if (cmd.pop_front || cmd.pop_back) begin
      fill_next = fill - FW'(1);
    end else if (cmd.clear) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (cmd.push) begin
        head <= push_slot;
      end else if (cmd.pop_front) begin
        head <= (head == LAST) ? '0 : head + AW'(1);
      end else if (cmd.clear) begin
        head <= '0;
      end
    end
  end

  always_comb begin
    st.action = req_action;
    st.full   = (fill == FULL_N);
    st.empty  = (fill == '0);
    st.pos_ok = (CW'(req_pos) < CW'(fill));
    st.match  = (mem_q == req_word);
    st.more   = ((FW + 1)'(idx) + (FW + 1)'(1)) < (FW + 1)'(fill);
  end

  assign q_wide = 64'(mem_q);

  // result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res;
    end
    if (cmd.res) begin
      status   <= cmd.res_status;
      data     <= (cmd.res_kind == bls_pkg::RES_PLAIN) ? '0 : q_wide[31:0];
      found_at <= (cmd.res_kind == bls_pkg::RES_FOUND) ? bls_pkg::FOUND_W'(idx) : '0;
      count    <= bls_pkg::COUNT_W'(fill_next);
      is_empty <= (fill_next == '0);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_N) else $error("fill above depth");
  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    (AW + 1)'(head) < DEPTH_S) else $error("head slot out of range");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (fill != FULL_N)) else $error("push into full list");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_back) |-> (fill != '0)) else $error("pop from empty list");
  a_one_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.rd)) else $error("memory write and read together");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> (fill == $past(fill) + FW'(1))) else $error("push did not grow list");
`endif

endmodule

[hw/rtl/bounded_list_store.sv]
// bounded_list_store: bounded ordered list of words in a ring with head slot and count
// top level; joins bls_ctrl and bls_dp, uses bls_pkg
//
//   channel   handshake           payload
//   request   start, busy         action, value, position
//   result    done (strobe)       status, data, found_at, count, is_empty
//
// a request is taken at an edge with start high and busy low
// push, clear, failed actions: result from exec; pops and reads: from the wait state
// search: one memory read per entry, front first, until the first match
// the entry memory has one port with a registered read; pops and reads wait for it
// rst (synchronous) empties the list; done is high one cycle and is never held off
module bounded_list_store #(
  parameter int DEPTH     = bls_pkg::DEPTH_DEF,
  parameter int WORD_BITS = bls_pkg::WORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [bls_pkg::ACTION_W-1:0]       action,
  input  logic signed [bls_pkg::VALUE_W-1:0] value,
  input  logic [bls_pkg::POSITION_W-1:0]     position,
  output logic                               done,
  output logic [bls_pkg::STATUS_W-1:0]       status,
  output logic signed [bls_pkg::VALUE_W-1:0] data,
  output logic [bls_pkg::FOUND_W-1:0]        found_at,
  output logic [bls_pkg::COUNT_W-1:0]        count,
  output logic                               is_empty
);

  bls_pkg::bls_cmd_t  cmd;
  bls_pkg::bls_stat_t st;

  bls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  bls_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .action   (action),
    .value    (value),
    .position (position),
    .done     (done),
    .status   (status),
    .data     (data),
    .found_at (found_at),
    .count    (count),
    .is_empty (is_empty)
  );

endmodule

[verif/bls_list_checker.sv]
`timescale 1ns / 100ps
// bls_list_checker: watches the request and result channels of bounded_list_store
// keeps its own copy of the ring, head and count and predicts every result
// depends on bls_pkg for the action and status codes
module bls_list_checker #(
  parameter int DEPTH = bls_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic [bls_pkg::ACTION_W-1:0]       action,
  input  logic signed [bls_pkg::VALUE_W-1:0] value,
  input  logic [bls_pkg::POSITION_W-1:0]     position,
  input  logic                               done,
  input  logic [bls_pkg::STATUS_W-1:0]       status,
  input  logic signed [bls_pkg::VALUE_W-1:0] data,
  input  logic [bls_pkg::FOUND_W-1:0]        found_at,
  input  logic [bls_pkg::COUNT_W-1:0]        count,
  input  logic                               is_empty,
  output int                                 fails,
  output int                                 outstanding,
  output int                                 checked,
  output int                                 full_hits,
  output int                                 deepest_hit
);
  import bls_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [FOUND_W-1:0]  found_at;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
  } list_result_t;

  logic [VALUE_W-1:0] ring [DEPTH];
  int                 head;
  int                 fill;
  list_result_t       pending_results [$];

  // one list action on the shadow copy, returns the result it should give
  task automatic apply_list_action(input logic [ACTION_W-1:0] act,
                                   input logic [VALUE_W-1:0] word,
                                   input logic [POSITION_W-1:0] pos,
                                   output list_result_t r);
    int   i;
    logic hit;
    r = '0;
    r.status = ST_NONE;
    hit = 1'b0;
    case (act)
      ACT_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = word;
          fill++;
          r.status = ST_DONE;
        end
      end
      ACT_POP_FRONT: begin
        if (fill != 0) begin
          r.data = ring[head];
          head = (head + 1) % DEPTH;
          fill--;
          r.status = ST_DONE;
        end
      end
      ACT_POP_BACK: begin
        if (fill != 0) begin
          r.data = ring[(head + fill - 1) % DEPTH];
          fill--;
          r.status = ST_DONE;
        end
      end
      ACT_READ: begin
        if (int'(pos) < fill) begin
          r.data = ring[(head + int'(pos)) % DEPTH];
          r.status = ST_DONE;
        end
      end
      ACT_SEARCH: begin
        for (i = 0; i < fill; i++) begin
          if (!hit && ring[(head + i) % DEPTH] == word) begin
            hit = 1'b1;
            r.data = word;
            r.found_at = i[FOUND_W-1:0];
            r.status = ST_DONE;
          end
        end
      end
      ACT_CLEAR: begin
        fill = 0;
        head = 0;
        r.status = ST_DONE;
      end
      default: ;
    endcase
    r.count = fill[COUNT_W-1:0];
    r.is_empty = (fill == 0);
  endtask

  always @(posedge clk) begin : watch
    list_result_t want;
    list_result_t next_want;
    logic         bad;
    if (rst) begin
      head = 0;
      fill = 0;
      pending_results.delete();
      fails <= 0;
      outstanding <= 0;
      checked <= 0;
      full_hits <= 0;
      deepest_hit <= 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result with no transaction pending");
          fails <= fails + 1;
        end else begin
          want = pending_results.pop_front();
          bad = 1'b0;
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            bad = 1'b1;
          end
          if (data !== want.data) begin
            $error("data: expected %0d, got %0d", $signed(want.data), data);
            bad = 1'b1;
          end
          if (found_at !== want.found_at) begin
            $error("found_at: expected %0d, got %0d", want.found_at, found_at);
            bad = 1'b1;
          end
          if (count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count);
            bad = 1'b1;
          end
          if (is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
            bad = 1'b1;
          end
          if (bad) fails <= fails + 1;
          checked <= checked + 1;
        end
      end
      if (start && !busy) begin
        apply_list_action(action, value, position, next_want);
        pending_results.push_back(next_want);
        if (action == ACT_PUSH_FRONT && next_want.status == ST_FULL) full_hits <= full_hits + 1;
        if (action == ACT_SEARCH && next_want.status == ST_DONE &&
            int'(next_want.found_at) > deepest_hit) begin
          deepest_hit <= int'(next_want.found_at);
        end
      end
      outstanding <= pending_results.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// testbench: stimulus and verdict for bounded_list_store
// drives directed and random list actions; checking is done by bls_list_checker
// depends on bls_pkg, bounded_list_store and bls_list_checker
module testbench;
  import bls_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 530;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 24;

  // action codes the block does not define
  localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd7;

  typedef enum int {GROW, SHRINK, MIX, PACK} seg_mode_t;

  localparam logic [ACTION_W-1:0] ACT_ORDER [6] = '{
    ACT_PUSH_FRONT, ACT_POP_FRONT, ACT_POP_BACK, ACT_READ, ACT_SEARCH, ACT_CLEAR
  };
  // cumulative percent cut points per mode, in the order above; the rest is reserved codes
  localparam int ACT_CUT [3][6] = '{
    '{70, 78, 84, 90, 97, 98},
    '{15, 45, 75, 85, 95, 97},
    '{30, 40, 50, 72, 94, 96}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [ACTION_W-1:0]         action = ACT_CLEAR;
  logic signed [VALUE_W-1:0]   value = '0;
  logic [POSITION_W-1:0]       position = '0;
  logic                        done;
  logic [STATUS_W-1:0]         status;
  logic signed [VALUE_W-1:0]   data;
  logic [FOUND_W-1:0]          found_at;
  logic [COUNT_W-1:0]          count;
  logic                        is_empty;

  int fails;
  int outstanding;
  int checked;
  int full_hits;
  int deepest_hit;

  // stimulus-side view of the list, used only to aim reads and searches and to size fill-up segments
  int                 est_fill = 0;
  logic [VALUE_W-1:0] recent [DEPTH];
  int                 recent_cnt = 0;
  int                 recent_wr = 0;
  int                 items_sent = 0;
  int                 idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bounded_list_store dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .value(value), .position(position),
    .done(done), .status(status), .data(data), .found_at(found_at),
    .count(count), .is_empty(is_empty)
  );

  bls_list_checker #(.DEPTH(DEPTH)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .action(action), .value(value), .position(position),
    .done(done), .status(status), .data(data), .found_at(found_at),
    .count(count), .is_empty(is_empty),
    .fails(fails), .outstanding(outstanding), .checked(checked),
    .full_hits(full_hits), .deepest_hit(deepest_hit)
  );

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [VALUE_W-1:0] corner_word();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] word,
                      input logic [POSITION_W-1:0] pos);
    start <= 1'b1;
    action <= act;
    value <= word;
    position <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    case (act)
      ACT_PUSH_FRONT: begin
        if (est_fill < DEPTH) begin
          recent[recent_wr] = word;
          recent_wr = (recent_wr + 1) % DEPTH;
          if (recent_cnt < DEPTH) recent_cnt++;
          est_fill++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: if (est_fill > 0) est_fill--;
      ACT_CLEAR: est_fill = 0;
      default: ;
    endcase
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // stop sending until every predicted result has come back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    seg_mode_t            mode;
    int                   seg_len;
    int                   r;
    int                   j;
    int                   k;
    int                   gap;
    int                   rand_sent;
    logic                 no_idle;
    logic [ACTION_W-1:0]  act;
    logic [VALUE_W-1:0]   word;
    logic [POSITION_W-1:0] pos;

    rand_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list corners, reserved codes, extreme words, bad positions
    send(ACT_POP_FRONT, 32'h1234_5678, 8'd0);
    send(ACT_POP_BACK, '0, 8'd0);
    send(ACT_READ, '0, 8'd0);
    send(ACT_SEARCH, '0, 8'd0);
    send(ACT_RSVD_A, '1, 8'hff);
    idle_gap($urandom_range(0, 2));
    send(ACT_RSVD_B, '0, 8'd0);
    send(ACT_PUSH_FRONT, 32'h7fff_ffff, 8'd0);
    send(ACT_PUSH_FRONT, 32'h8000_0000, 8'd0);
    idle_gap($urandom_range(0, 2));
    send(ACT_PUSH_FRONT, '0, 8'd0);
    send(ACT_PUSH_FRONT, '1, 8'd0);
    send(ACT_READ, '0, 8'd0);
    send(ACT_READ, '0, 8'd3);
    send(ACT_READ, '0, 8'd4);
    send(ACT_READ, '0, 8'hff);
    idle_gap($urandom_range(0, 2));
    send(ACT_SEARCH, 32'h8000_0000, 8'd0);
    send(ACT_SEARCH, 32'h1234_5678, 8'd0);
    send(ACT_POP_FRONT, '0, 8'd0);
    send(ACT_POP_BACK, '0, 8'd0);
    send(ACT_CLEAR, '0, 8'd0);
    send(ACT_READ, '0, 8'd0);
    send(ACT_POP_BACK, '0, 8'd0);
    send(ACT_PUSH_FRONT, 32'h5555_5555, 8'd0);
    send(ACT_PUSH_FRONT, 32'haaaa_aaaa, 8'd0);
    send(ACT_SEARCH, 32'haaaa_aaaa, 8'd0);
    settle();

    while (rand_sent < RANDOM_ITEMS) begin
      mode = seg_mode_t'($urandom_range(0, 3));
      no_idle = ($urandom_range(0, 3) == 0);
      seg_len = (mode == PACK) ? DEPTH - est_fill + 6 : $urandom_range(8, 30);
      for (j = 0; j < seg_len; j++) begin
        if (mode == PACK) begin
          // fill to the brim, overflow twice, then look deep into the list
          act = (j < seg_len - 4) ? ACT_PUSH_FRONT : ACT_SEARCH;
        end else begin
          r = $urandom_range(0, 99);
          act = $urandom_range(0, 1) ? ACT_RSVD_A : ACT_RSVD_B;
          for (k = 5; k >= 0; k--) begin
            if (r < ACT_CUT[int'(mode)][k]) act = ACT_ORDER[k];
          end
        end

        r = $urandom_range(0, 9);
        if (act == ACT_PUSH_FRONT) begin
          if (r == 0) word = corner_word();
          else if (r < 3) word = $urandom_range(0, 3);
          else word = $urandom;
        end else if (act == ACT_SEARCH) begin
          if (r < 6 && recent_cnt > 0) word = recent[$urandom_range(0, recent_cnt - 1)];
          else if (r < 8) word = corner_word();
          else if (r == 8) word = $urandom_range(0, 3);
          else word = $urandom;
        end else begin
          word = $urandom;
        end

        if (act == ACT_READ && $urandom_range(0, 9) < 7) pos = 8'($urandom_range(0, est_fill));
        else pos = 8'($urandom_range(0, 255));

        send(act, word, pos);
        rand_sent++;

        r = $urandom_range(0, 19);
        if (no_idle || r < 12) gap = 0;
        else if (r < 18) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        idle_gap(gap);
      end
      if ($urandom_range(0, 7) == 0) settle();
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions sent, %0d results compared", items_sent, checked);
    $display("%0d pushes refused on a full list, deepest search hit at position %0d",
             full_hits, deepest_hit);
    if (fails == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
